// ===== src/cau_pkg.sv =====
// shared types, constants, pipeline schedule and saturating helpers of the cau block
package cau_pkg;

    // fixed point format and unit latencies
    localparam int W           = 64;
    localparam int FB          = 32;
    localparam int LAT_WMUL    = 2;
    localparam int LAT_MUL     = LAT_WMUL + 2;
    localparam int SQ_STEPS    = W;
    localparam int LAT_NORM    = LAT_WMUL + SQ_STEPS + 3;
    localparam int DIV_BITS    = W + FB;
    localparam int LAT_DIV     = DIV_BITS + 2;

    // schedule: cycle after input capture at which each value sits in a register
    localparam int T_GN        = LAT_NORM;
    localparam int T_A         = LAT_MUL + 1;
    localparam int T_SU        = LAT_MUL;
    localparam int T_R1        = LAT_DIV + 1;
    localparam int T_R         = T_R1 + 3;
    localparam int T_G2        = T_GN + LAT_MUL;
    localparam int T_Q         = T_G2 + LAT_DIV;
    localparam int T_QV        = T_Q + LAT_MUL;
    localparam int T_BN        = T_QV + LAT_NORM;
    localparam int T_B2        = T_BN + LAT_MUL;
    localparam int T_B3        = T_B2 + LAT_MUL;
    localparam int T_HB3       = T_B3 + LAT_MUL;
    localparam int T_PE        = T_HB3 + LAT_DIV;
    localparam int T_HA        = T_PE + LAT_MUL;
    localparam int T_X         = T_HA + LAT_MUL;
    localparam int T_RES       = T_X + LAT_DIV;
    localparam int CAU_LATENCY = T_RES + 1;

    // configuration port
    localparam int CFG_ADDR_W  = 5;
    localparam int CFG_IDX_LSB = 3;

    typedef enum logic [1:0] {
        REG_REACTION    = 2'd0,
        REG_DIFFUSIVITY = 2'd1,
        REG_TIME_STEP   = 2'd2
    } cfg_reg_t;

    typedef logic signed [W-1:0] fx_t;
    typedef logic [W-1:0]        mag_t;
    typedef logic [2*W-1:0]      wide_t;

    localparam fx_t FX_MAX = {1'b0, {(W-1){1'b1}}};
    localparam fx_t FX_MIN = {1'b1, {(W-1){1'b0}}};
    localparam fx_t FX_LSB = fx_t'(1);
    localparam fx_t FX_ONE = fx_t'(1) << FB;

    function automatic mag_t mag(input fx_t a);
        return a[W-1] ? mag_t'(-a) : mag_t'(a);
    endfunction

    // signed value from sign, overflow flag and magnitude, saturated
    function automatic fx_t from_mag(input logic neg, input logic over, input mag_t m);
        if (!neg)
        begin
            return (over || m[W-1]) ? FX_MAX : fx_t'(m);
        end
        return (over || m[W-1]) ? FX_MIN : fx_t'(mag_t'(0) - m);
    endfunction

    function automatic fx_t sat_add(input fx_t a, input fx_t b);
        logic [W:0] s;
        s = {a[W-1], a} + {b[W-1], b};
        if (s[W] != s[W-1])
        begin
            return s[W] ? FX_MIN : FX_MAX;
        end
        return fx_t'(s[W-1:0]);
    endfunction

    function automatic fx_t sat_sub(input fx_t a, input fx_t b);
        logic [W:0] s;
        s = {a[W-1], a} - {b[W-1], b};
        if (s[W] != s[W-1])
        begin
            return s[W] ? FX_MIN : FX_MAX;
        end
        return fx_t'(s[W-1:0]);
    endfunction

    function automatic fx_t floor_lsb(input fx_t v);
        return (v < FX_LSB) ? FX_LSB : v;
    endfunction

endpackage

// ===== src/cau_shock_capturing_coefficient.sv =====
// CAU shock-capturing coefficient: fully pipelined top level
//
// Usage: one quadrature point per item. Raise start with the eight field
// ports valid; busy stays low, so an item is taken at every clock edge at
// which start is high. Items may enter in every cycle.
// Result: cau_coeff is shown for exactly one cycle with done high, in item
// order, from the output register of the final divider.
// Throughput: one item per clock. The latency is set by the chain of
// norm, divide and multiply units along the projection path: two norms,
// three dividers (one quotient bit per stage) and seven multiplies, plus
// the input capture register.
// Configuration: APB registers reaction_coeff, diffusivity and time_step at
// byte addresses 0, 8 and 16; write them only while no item is in flight.
// Reset: rst_n clears all valid bits, so items in flight are dropped, and
// loads the registers with sigma 0, K 1.0 and dt 1.0.
// The receiver cannot stall; the pipeline advances every cycle.
module cau_shock_capturing_coefficient (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  cau_pkg::fx_t                   value_now,
    input  cau_pkg::fx_t                   value_prev,
    input  cau_pkg::fx_t                   grad_x,
    input  cau_pkg::fx_t                   grad_y,
    input  cau_pkg::fx_t                   source_term,
    input  cau_pkg::fx_t                   vel_x,
    input  cau_pkg::fx_t                   vel_y,
    input  logic [cau_pkg::W-2:0]          elem_size,
    output logic                           done,
    output cau_pkg::fx_t                   cau_coeff,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [cau_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [cau_pkg::W-1:0]          pwdata,
    output logic [cau_pkg::W-1:0]          prdata,
    output logic                           pready
);

    localparam int LM       = cau_pkg::LAT_MUL;
    localparam int IDX_A_R  = cau_pkg::T_R1 - cau_pkg::T_A - 1;
    localparam int IDX_A_Q  = cau_pkg::T_G2 - cau_pkg::T_A - 1;
    localparam int LEN_A    = ((IDX_A_R > IDX_A_Q) ? IDX_A_R : IDX_A_Q) + 1;
    localparam int LEN_SU   = cau_pkg::T_R1 + 1 - cau_pkg::T_SU;
    localparam int LEN_F    = cau_pkg::T_R1 + 2;
    localparam int LEN_G    = cau_pkg::T_Q;
    localparam int LEN_H    = cau_pkg::T_PE;
    localparam int LEN_R    = cau_pkg::T_HA - cau_pkg::T_R;
    localparam int LEN_GN   = cau_pkg::T_X - cau_pkg::T_GN;

    // configuration registers
    cau_pkg::fx_t          reaction_reg;
    logic [cau_pkg::W-2:0] diffusivity_reg;
    logic [cau_pkg::W-2:0] time_step_reg;
    cau_pkg::cfg_reg_t     cfg_sel;
    logic                  cfg_wr;

    // input capture
    logic         vld0_reg;
    logic         vld1_reg;
    cau_pkg::fx_t u_reg;
    cau_pkg::fx_t up_reg;
    cau_pkg::fx_t gx_reg;
    cau_pkg::fx_t gy_reg;
    cau_pkg::fx_t f_reg;
    cau_pkg::fx_t vx_reg;
    cau_pkg::fx_t vy_reg;
    cau_pkg::fx_t h_reg;
    cau_pkg::fx_t du_reg;

    // datapath values
    cau_pkg::fx_t gn_raw;
    cau_pkg::fx_t gn;
    logic         gn_vld;
    cau_pkg::fx_t pvx;
    cau_pkg::fx_t pvy;
    cau_pkg::fx_t su;
    cau_pkg::fx_t a_reg;
    cau_pkg::fx_t r1;
    cau_pkg::fx_t ra_reg;
    cau_pkg::fx_t rb_reg;
    cau_pkg::fx_t r_reg;
    cau_pkg::fx_t g2_raw;
    logic         g2_vld;
    cau_pkg::fx_t q;
    logic         q_vld;
    cau_pkg::fx_t qx;
    cau_pkg::fx_t qy;
    logic         qx_vld;
    cau_pkg::fx_t bn_raw;
    cau_pkg::fx_t bn;
    logic         bn_vld;
    cau_pkg::fx_t b2;
    logic         b2_vld;
    cau_pkg::fx_t d_raw;
    cau_pkg::fx_t b3;
    logic         b3_vld;
    cau_pkg::fx_t hb3;
    logic         hb3_vld;
    cau_pkg::fx_t pe;
    logic         pe_vld;
    cau_pkg::fx_t pe_q;
    cau_pkg::fx_t alpha;
    cau_pkg::fx_t ha;
    logic         ha_vld;
    cau_pkg::fx_t xv;
    logic         x_vld;

    // alignment lines
    cau_pkg::fx_t a_line  [LEN_A];
    cau_pkg::fx_t su_line [LEN_SU];
    cau_pkg::fx_t f_line  [LEN_F];
    cau_pkg::fx_t gx_line [LEN_G];
    cau_pkg::fx_t gy_line [LEN_G];
    cau_pkg::fx_t h_line  [LEN_H];
    cau_pkg::fx_t r_line  [LEN_R];
    cau_pkg::fx_t gn_line [LEN_GN];
    cau_pkg::fx_t bn_line [LM];
    cau_pkg::fx_t d_line  [LM];

    assign busy   = 1'b0;
    assign pready = 1'b1;

    // register file
    assign cfg_sel = cau_pkg::cfg_reg_t'(paddr[cau_pkg::CFG_ADDR_W-1:cau_pkg::CFG_IDX_LSB]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reaction_reg    <= '0;
            diffusivity_reg <= cau_pkg::FX_ONE[cau_pkg::W-2:0];
            time_step_reg   <= cau_pkg::FX_ONE[cau_pkg::W-2:0];
        end
        else if (cfg_wr)
        begin
            unique case (cfg_sel)
                cau_pkg::REG_REACTION:    reaction_reg    <= cau_pkg::fx_t'(pwdata);
                cau_pkg::REG_DIFFUSIVITY: diffusivity_reg <= pwdata[cau_pkg::W-2:0];
                cau_pkg::REG_TIME_STEP:   time_step_reg   <= pwdata[cau_pkg::W-2:0];
                default:                  ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            cau_pkg::REG_REACTION:    prdata = reaction_reg;
            cau_pkg::REG_DIFFUSIVITY: prdata = {1'b0, diffusivity_reg};
            cau_pkg::REG_TIME_STEP:   prdata = {1'b0, time_step_reg};
            default:                  prdata = '0;
        endcase
    end

    // item valid bits at the head of the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld0_reg <= 1'b0;
            vld1_reg <= 1'b0;
        end
        else
        begin
            vld0_reg <= start && !busy;
            vld1_reg <= vld0_reg;
        end
    end

    // input capture and time difference
    always_ff @(posedge clk)
    begin
        u_reg  <= value_now;
        up_reg <= value_prev;
        gx_reg <= grad_x;
        gy_reg <= grad_y;
        f_reg  <= source_term;
        vx_reg <= vel_x;
        vy_reg <= vel_y;
        h_reg  <= cau_pkg::fx_t'({1'b0, elem_size});
        du_reg <= cau_pkg::sat_sub(u_reg, up_reg);
    end

    // gradient norm
    cau_norm u_norm_g (
        .clk     (clk),
        .rst_n   (rst_n),
        .vld_in  (vld0_reg),
        .x       (gx_reg),
        .y       (gy_reg),
        .vld_out (gn_vld),
        .norm    (gn_raw)
    );

    assign gn = cau_pkg::floor_lsb(gn_raw);

    // advective rate and reaction term
    cau_mul u_mul_vx (
        .clk (clk), .rst_n (rst_n), .vld_in (vld0_reg),
        .a (vx_reg), .b (gx_reg), .vld_out (), .prod (pvx)
    );

    cau_mul u_mul_vy (
        .clk (clk), .rst_n (rst_n), .vld_in (vld0_reg),
        .a (vy_reg), .b (gy_reg), .vld_out (), .prod (pvy)
    );

    cau_mul u_mul_su (
        .clk (clk), .rst_n (rst_n), .vld_in (vld0_reg),
        .a (reaction_reg), .b (u_reg), .vld_out (), .prod (su)
    );

    always_ff @(posedge clk)
    begin
        a_reg <= cau_pkg::sat_add(pvx, pvy);
    end

    // time derivative
    cau_div u_div_r1 (
        .clk (clk), .rst_n (rst_n), .vld_in (vld1_reg),
        .num (du_reg),
        .den (cau_pkg::floor_lsb(cau_pkg::fx_t'({1'b0, time_step_reg}))),
        .vld_out (), .quo (r1)
    );

    // residual, one saturating add or subtract per stage
    always_ff @(posedge clk)
    begin
        ra_reg <= cau_pkg::sat_add(r1, a_line[IDX_A_R]);
        rb_reg <= cau_pkg::sat_sub(ra_reg, su_line[LEN_SU-1]);
        r_reg  <= cau_pkg::sat_sub(rb_reg, f_line[LEN_F-1]);
    end

    // squared gradient norm and projection factor
    cau_mul u_mul_g2 (
        .clk (clk), .rst_n (rst_n), .vld_in (gn_vld),
        .a (gn), .b (gn), .vld_out (g2_vld), .prod (g2_raw)
    );

    cau_div u_div_q (
        .clk (clk), .rst_n (rst_n), .vld_in (g2_vld),
        .num (a_line[IDX_A_Q]), .den (cau_pkg::floor_lsb(g2_raw)),
        .vld_out (q_vld), .quo (q)
    );

    // projected advection
    cau_mul u_mul_qx (
        .clk (clk), .rst_n (rst_n), .vld_in (q_vld),
        .a (q), .b (gx_line[LEN_G-1]), .vld_out (qx_vld), .prod (qx)
    );

    cau_mul u_mul_qy (
        .clk (clk), .rst_n (rst_n), .vld_in (q_vld),
        .a (q), .b (gy_line[LEN_G-1]), .vld_out (), .prod (qy)
    );

    cau_norm u_norm_b (
        .clk     (clk),
        .rst_n   (rst_n),
        .vld_in  (qx_vld),
        .x       (qx),
        .y       (qy),
        .vld_out (bn_vld),
        .norm    (bn_raw)
    );

    assign bn = cau_pkg::floor_lsb(bn_raw);

    // powers of |b| and diffusive scale
    cau_mul u_mul_b2 (
        .clk (clk), .rst_n (rst_n), .vld_in (bn_vld),
        .a (bn), .b (bn), .vld_out (b2_vld), .prod (b2)
    );

    cau_mul u_mul_d (
        .clk (clk), .rst_n (rst_n), .vld_in (b2_vld),
        .a (cau_pkg::fx_t'({1'b0, diffusivity_reg})), .b (b2),
        .vld_out (), .prod (d_raw)
    );

    cau_mul u_mul_b3 (
        .clk (clk), .rst_n (rst_n), .vld_in (b2_vld),
        .a (b2), .b (bn_line[LM-1]), .vld_out (b3_vld), .prod (b3)
    );

    cau_mul u_mul_hb3 (
        .clk (clk), .rst_n (rst_n), .vld_in (b3_vld),
        .a (h_line[cau_pkg::T_B3-1]), .b (b3), .vld_out (hb3_vld), .prod (hb3)
    );

    // peclet number
    cau_div u_div_pe (
        .clk (clk), .rst_n (rst_n), .vld_in (hb3_vld),
        .num (hb3 >>> 1), .den (cau_pkg::floor_lsb(d_line[LM-1])),
        .vld_out (pe_vld), .quo (pe)
    );

    // limiter
    assign pe_q  = pe >>> 2;
    assign alpha = (pe_q > cau_pkg::FX_ONE) ? cau_pkg::FX_ONE : pe_q;

    cau_mul u_mul_ha (
        .clk (clk), .rst_n (rst_n), .vld_in (pe_vld),
        .a (h_line[LEN_H-1]), .b (alpha), .vld_out (ha_vld), .prod (ha)
    );

    cau_mul u_mul_x (
        .clk (clk), .rst_n (rst_n), .vld_in (ha_vld),
        .a (ha >>> 1), .b (r_line[LEN_R-1]), .vld_out (x_vld), .prod (xv)
    );

    // final scaling by the gradient norm
    cau_div u_div_res (
        .clk (clk), .rst_n (rst_n), .vld_in (x_vld),
        .num (xv), .den (gn_line[LEN_GN-1]),
        .vld_out (done), .quo (cau_coeff)
    );

    // alignment shift lines
    always_ff @(posedge clk)
    begin
        a_line[0]  <= a_reg;
        su_line[0] <= su;
        f_line[0]  <= f_reg;
        gx_line[0] <= gx_reg;
        gy_line[0] <= gy_reg;
        h_line[0]  <= h_reg;
        r_line[0]  <= r_reg;
        gn_line[0] <= gn;
        bn_line[0] <= bn;
        d_line[0]  <= d_raw;
        for (int i = 1; i < LEN_A; i++)
        begin
            a_line[i] <= a_line[i-1];
        end
        for (int i = 1; i < LEN_SU; i++)
        begin
            su_line[i] <= su_line[i-1];
        end
        for (int i = 1; i < LEN_F; i++)
        begin
            f_line[i] <= f_line[i-1];
        end
        for (int i = 1; i < LEN_G; i++)
        begin
            gx_line[i] <= gx_line[i-1];
            gy_line[i] <= gy_line[i-1];
        end
        for (int i = 1; i < LEN_H; i++)
        begin
            h_line[i] <= h_line[i-1];
        end
        for (int i = 1; i < LEN_R; i++)
        begin
            r_line[i] <= r_line[i-1];
        end
        for (int i = 1; i < LEN_GN; i++)
        begin
            gn_line[i] <= gn_line[i-1];
        end
        for (int i = 1; i < LM; i++)
        begin
            bn_line[i] <= bn_line[i-1];
            d_line[i]  <= d_line[i-1];
        end
    end

endmodule

// ===== src/cau_wmul.sv =====
// unsigned full-width product from four registered half-width partial products
module cau_wmul (
    input  logic           clk,
    input  cau_pkg::mag_t  a,
    input  cau_pkg::mag_t  b,
    output cau_pkg::wide_t prod
);

    localparam int H = cau_pkg::W / 2;

    logic [cau_pkg::W-1:0] p00_reg;
    logic [cau_pkg::W-1:0] p01_reg;
    logic [cau_pkg::W-1:0] p10_reg;
    logic [cau_pkg::W-1:0] p11_reg;
    cau_pkg::wide_t        prod_reg;

    // partial products
    always_ff @(posedge clk)
    begin
        p00_reg <= a[H-1:0] * b[H-1:0];
        p01_reg <= a[H-1:0] * b[cau_pkg::W-1:H];
        p10_reg <= a[cau_pkg::W-1:H] * b[H-1:0];
        p11_reg <= a[cau_pkg::W-1:H] * b[cau_pkg::W-1:H];
    end

    // recombine
    always_ff @(posedge clk)
    begin
        prod_reg <= {p11_reg, p00_reg}
                  + (cau_pkg::wide_t'(p01_reg) << H)
                  + (cau_pkg::wide_t'(p10_reg) << H);
    end

    assign prod = prod_reg;

endmodule

// ===== src/cau_mul.sv =====
// pipelined signed fixed-point multiply with truncation toward zero and saturation
module cau_mul (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         vld_in,
    input  cau_pkg::fx_t a,
    input  cau_pkg::fx_t b,
    output logic         vld_out,
    output cau_pkg::fx_t prod
);

    localparam int LM = cau_pkg::LAT_MUL;

    logic [LM-1:0]  vld_reg;
    logic [LM-2:0]  neg_reg;
    cau_pkg::mag_t  ma_reg;
    cau_pkg::mag_t  mb_reg;
    cau_pkg::wide_t wprod;
    cau_pkg::fx_t   res_reg;

    // valid travels with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[LM-2:0], vld_in};
        end
    end

    // magnitudes and sign
    always_ff @(posedge clk)
    begin
        ma_reg  <= cau_pkg::mag(a);
        mb_reg  <= cau_pkg::mag(b);
        neg_reg <= {neg_reg[LM-3:0], a[cau_pkg::W-1] ^ b[cau_pkg::W-1]};
    end

    cau_wmul u_wmul (
        .clk  (clk),
        .a    (ma_reg),
        .b    (mb_reg),
        .prod (wprod)
    );

    // drop fraction bits, saturate
    always_ff @(posedge clk)
    begin
        res_reg <= cau_pkg::from_mag(neg_reg[LM-2],
                                     |wprod[2*cau_pkg::W-1:cau_pkg::W+cau_pkg::FB],
                                     wprod[cau_pkg::W+cau_pkg::FB-1:cau_pkg::FB]);
    end

    assign vld_out = vld_reg[LM-1];
    assign prod    = res_reg;

endmodule

// ===== src/cau_norm.sv =====
// pipelined 2-d euclidean norm: squares, sum, one root bit per stage
module cau_norm (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         vld_in,
    input  cau_pkg::fx_t x,
    input  cau_pkg::fx_t y,
    output logic         vld_out,
    output cau_pkg::fx_t norm
);

    localparam int LN    = cau_pkg::LAT_NORM;
    localparam int SQ    = cau_pkg::SQ_STEPS;
    localparam int REM_W = cau_pkg::W + 3;

    typedef struct packed {
        logic [REM_W-1:0]      rem;
        logic [cau_pkg::W-1:0] root;
    } sq_t;

    logic [LN-1:0]  vld_reg;
    cau_pkg::mag_t  mx_reg;
    cau_pkg::mag_t  my_reg;
    cau_pkg::wide_t sx;
    cau_pkg::wide_t sy;
    cau_pkg::wide_t sum_reg;
    sq_t            st_reg   [SQ];
    cau_pkg::wide_t rest_reg [SQ];
    sq_t            st_in    [SQ];
    cau_pkg::wide_t rest_in  [SQ];
    cau_pkg::fx_t   norm_reg;

    // one digit of the square root
    function automatic sq_t sq_step(input sq_t cur, input logic [1:0] pair);
        sq_t              nxt;
        logic [REM_W-1:0] rem_n;
        logic [REM_W-1:0] trial;
        rem_n = {cur.rem[REM_W-3:0], pair};
        trial = REM_W'({cur.root, 2'b01});
        if (rem_n >= trial)
        begin
            nxt.rem  = rem_n - trial;
            nxt.root = {cur.root[cau_pkg::W-2:0], 1'b1};
        end
        else
        begin
            nxt.rem  = rem_n;
            nxt.root = {cur.root[cau_pkg::W-2:0], 1'b0};
        end
        return nxt;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[LN-2:0], vld_in};
        end
    end

    // magnitudes
    always_ff @(posedge clk)
    begin
        mx_reg <= cau_pkg::mag(x);
        my_reg <= cau_pkg::mag(y);
    end

    cau_wmul u_sqx (
        .clk  (clk),
        .a    (mx_reg),
        .b    (mx_reg),
        .prod (sx)
    );

    cau_wmul u_sqy (
        .clk  (clk),
        .a    (my_reg),
        .b    (my_reg),
        .prod (sy)
    );

    // sum of squares fits in the wide word
    always_ff @(posedge clk)
    begin
        sum_reg <= sx + sy;
    end

    // stage inputs
    always_comb
    begin
        st_in[0]   = '0;
        rest_in[0] = sum_reg;
        for (int k = 1; k < SQ; k++)
        begin
            st_in[k]   = st_reg[k-1];
            rest_in[k] = rest_reg[k-1];
        end
    end

    // root stages
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < SQ; k++)
        begin
            st_reg[k]   <= sq_step(st_in[k], rest_in[k][2*cau_pkg::W-1:2*cau_pkg::W-2]);
            rest_reg[k] <= rest_in[k] << 2;
        end
    end

    // saturate to the signed maximum
    always_ff @(posedge clk)
    begin
        norm_reg <= st_reg[SQ-1].root[cau_pkg::W-1] ? cau_pkg::FX_MAX
                                                    : cau_pkg::fx_t'(st_reg[SQ-1].root);
    end

    assign vld_out = vld_reg[LN-1];
    assign norm    = norm_reg;

endmodule

// ===== src/cau_div.sv =====
// pipelined fixed-point divide, one restoring quotient bit per stage
module cau_div (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         vld_in,
    input  cau_pkg::fx_t num,
    input  cau_pkg::fx_t den,
    output logic         vld_out,
    output cau_pkg::fx_t quo
);

    localparam int LD = cau_pkg::LAT_DIV;
    localparam int DB = cau_pkg::DIV_BITS;

    typedef struct packed {
        logic [cau_pkg::W-1:0] rem;
        logic [DB-1:0]         q;
        logic [DB-1:0]         dvd;
        cau_pkg::mag_t         md;
        logic                  neg;
        logic                  zero;
    } dv_t;

    logic [LD-1:0] vld_reg;
    dv_t           s0_reg;
    dv_t           st_reg [DB];
    dv_t           st_in  [DB];
    cau_pkg::fx_t  quo_reg;

    // one restoring step
    function automatic dv_t dv_step(input dv_t cur);
        dv_t                 nxt;
        logic [cau_pkg::W:0] sh;
        nxt = cur;
        sh  = {cur.rem, cur.dvd[DB-1]};
        if (sh >= {1'b0, cur.md})
        begin
            nxt.rem = cau_pkg::W'(sh - {1'b0, cur.md});
            nxt.q   = {cur.q[DB-2:0], 1'b1};
        end
        else
        begin
            nxt.rem = sh[cau_pkg::W-1:0];
            nxt.q   = {cur.q[DB-2:0], 1'b0};
        end
        nxt.dvd = cur.dvd << 1;
        return nxt;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[LD-2:0], vld_in};
        end
    end

    // operand setup: scaled dividend, divisor magnitude, sign, zero over zero
    always_ff @(posedge clk)
    begin
        s0_reg.rem  <= '0;
        s0_reg.q    <= '0;
        s0_reg.dvd  <= {cau_pkg::mag(num), {cau_pkg::FB{1'b0}}};
        s0_reg.md   <= cau_pkg::mag(den);
        s0_reg.neg  <= num[cau_pkg::W-1] ^ den[cau_pkg::W-1];
        s0_reg.zero <= (num == '0) && (den == '0);
    end

    always_comb
    begin
        st_in[0] = s0_reg;
        for (int k = 1; k < DB; k++)
        begin
            st_in[k] = st_reg[k-1];
        end
    end

    // quotient stages
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < DB; k++)
        begin
            st_reg[k] <= dv_step(st_in[k]);
        end
    end

    // saturate, or give zero for zero over zero
    always_ff @(posedge clk)
    begin
        if (st_reg[DB-1].zero)
        begin
            quo_reg <= '0;
        end
        else
        begin
            quo_reg <= cau_pkg::from_mag(st_reg[DB-1].neg,
                                         |st_reg[DB-1].q[DB-1:cau_pkg::W],
                                         st_reg[DB-1].q[cau_pkg::W-1:0]);
        end
    end

    assign vld_out = vld_reg[LD-1];
    assign quo     = quo_reg;

endmodule

// ===== src/cau_checker.sv =====
// port-level checker for the cau block and its bind
module cau_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           start,
    input logic                           busy,
    input logic                           done,
    input logic                           psel,
    input logic                           penable,
    input logic                           pwrite,
    input logic [cau_pkg::CFG_ADDR_W-1:0] paddr,
    input logic [cau_pkg::W-1:0]          pwdata,
    input logic [cau_pkg::W-1:0]          prdata,
    input logic                           pready
);

    localparam int CW = $clog2(cau_pkg::CAU_LATENCY + 1);

    logic [CW-1:0] up_cnt_reg;
    logic          settled;
    logic          wr_react;
    logic          wr_step;
    logic          sel_react;
    logic          sel_step;

    // cycles since reset release, saturating at the pipeline latency
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_cnt_reg <= '0;
        end
        else if (up_cnt_reg != CW'(cau_pkg::CAU_LATENCY))
        begin
            up_cnt_reg <= up_cnt_reg + 1'b1;
        end
    end

    assign settled   = (up_cnt_reg == CW'(cau_pkg::CAU_LATENCY));
    assign sel_react = (paddr[cau_pkg::CFG_ADDR_W-1:cau_pkg::CFG_IDX_LSB]
                        == cau_pkg::REG_REACTION);
    assign sel_step  = (paddr[cau_pkg::CFG_ADDR_W-1:cau_pkg::CFG_IDX_LSB]
                        == cau_pkg::REG_TIME_STEP);
    assign wr_react  = psel && penable && pwrite && pready && sel_react;
    assign wr_step   = psel && penable && pwrite && pready && sel_step;

    // every item gives exactly one result after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        settled |-> (done == $past(start, cau_pkg::CAU_LATENCY)))
        else $error("result strobe does not match accepted item");

    // the block never refuses an item
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    // written reaction and time step registers read back
    a_read_react: assert property (@(posedge clk) disable iff (!rst_n)
        wr_react |=> (!sel_react || prdata == $past(pwdata)))
        else $error("reaction coefficient readback mismatch");

    a_read_step: assert property (@(posedge clk) disable iff (!rst_n)
        wr_step |=> (!sel_step || prdata == {1'b0, $past(pwdata[cau_pkg::W-2:0])}))
        else $error("time step readback mismatch");

endmodule

bind cau_shock_capturing_coefficient cau_checker u_cau_checker (.*);
